[rtl/core/energy_meter_frame_parser_macros.svh]
// Assertion macros for the energy meter frame parser.
`ifndef ENERGY_METER_FRAME_PARSER_MACROS_SVH
`define ENERGY_METER_FRAME_PARSER_MACROS_SVH
`ifndef SYNTH
`define EMFP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame parser assertion failed");
`define EMFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");
`else
`define EMFP_ASSERT_IMP(label, ante, cons)
`define EMFP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/emfp_pkg.sv]
// Types, constants and helper functions shared by the frame parser.
`timescale 1ns / 1ps
package emfp_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int POS_W       = 5;
    localparam int FIELD_COUNT = 6;
    localparam int FIDX_W      = 3;

    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FIELD_LAST = POS_W'(19);
    localparam logic [POS_W-1:0] POS_ADJUST = POS_W'(20);
    localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(FRAME_BYTES);

    localparam logic [7:0] HDR_NORMAL  = 8'h55;
    localparam logic [7:0] HDR_UNCAL   = 8'hAA;
    localparam logic [7:0] HDR_HIGH    = 8'hF0;
    localparam logic [7:0] HDR_SECOND  = 8'h5A;
    localparam logic [7:0] ADJ_VOLTAGE = 8'h40;
    localparam logic [7:0] ADJ_POWER   = 8'h10;
    localparam logic [7:0] ADJ_CURRENT = 8'h20;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNCAL      = 2'd1,
        ST_COEF_FAULT = 2'd2
    } t_status;

    typedef logic [23:0] t_word24;
    typedef t_word24 [FIELD_COUNT-1:0] t_fields;

    typedef struct packed {
        t_status status;
        logic    voltage_valid;
        logic    current_valid;
        logic    power_valid;
    } t_flags;

    typedef struct packed {
        logic pos_last;
        logic pos_zero;
        logic fire;
    } t_trk_stat;

    // Field slot for frame positions 2 to 19, three bytes to a field.
    function automatic logic [FIDX_W-1:0] f_field_idx(input logic [POS_W-1:0] pos);
        logic [FIDX_W-1:0] idx;
        case (pos)
            5'd2, 5'd3, 5'd4:    idx = 3'd0;
            5'd5, 5'd6, 5'd7:    idx = 3'd1;
            5'd8, 5'd9, 5'd10:   idx = 3'd2;
            5'd11, 5'd12, 5'd13: idx = 3'd3;
            5'd14, 5'd15, 5'd16: idx = 3'd4;
            default:             idx = 3'd5;
        endcase
        return idx;
    endfunction

endpackage

[rtl/core/emfp_if.sv]
// Handshake interfaces for the received byte and the parsed frame result.
`timescale 1ns / 1ps
interface emfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       gap_expired;

    modport source (output valid, output rx_byte, output gap_expired, input ready);
    modport sink (input valid, input rx_byte, input gap_expired, output ready);
endinterface

interface emfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic        voltage_valid;
    logic        current_valid;
    logic        power_valid;
    logic [23:0] voltage_param;
    logic [23:0] voltage_period;
    logic [23:0] current_param;
    logic [23:0] current_period;
    logic [23:0] power_param;
    logic [23:0] power_period;

    modport source (
        output valid, output frame_status, output voltage_valid, output current_valid,
        output power_valid, output voltage_param, output voltage_period,
        output current_param, output current_period, output power_param,
        output power_period, input ready
    );
    modport sink (
        input valid, input frame_status, input voltage_valid, input current_valid,
        input power_valid, input voltage_param, input voltage_period,
        input current_param, input current_period, input power_param,
        input power_period, output ready
    );
endinterface

[rtl/core/energy_meter_frame_parser.sv]
// A good frame's result becomes valid in the cycle after its checksum byte is accepted.
// One byte per cycle unless refused; the frame tracker and result register update together.
// A byte is refused only while the checksum position is reached and the result is unread.
// Reset (synchronous, active low) returns to frame position 0 and empties the result register.
// Captured field bytes are not cleared; every field is rewritten before a frame completes.
`timescale 1ns / 1ps
`include "energy_meter_frame_parser_macros.svh"
module energy_meter_frame_parser
    import emfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    emfp_in_if.sink     i_in,
    emfp_out_if.source  o_out
);

    t_trk_stat  s_trk;
    logic [7:0] s_header;
    logic [7:0] s_adjust;
    t_fields    s_fields;
    t_flags     s_flags;
    logic       s_out_busy;

    emfp_tracker u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_busy (s_out_busy),
        .o_stat     (s_trk),
        .o_header   (s_header),
        .o_adjust   (s_adjust),
        .o_fields   (s_fields)
    );

    emfp_status u_status (
        .i_header       (s_header),
        .i_adjust       (s_adjust),
        .i_power_param  (s_fields[4]),
        .i_power_period (s_fields[5]),
        .o_flags        (s_flags)
    );

    emfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_trk.fire),
        .i_flags  (s_flags),
        .i_fields (s_fields),
        .o_out    (o_out),
        .o_busy   (s_out_busy)
    );

    `EMFP_ASSERT_IMP(a_fire_on_check, s_trk.fire, s_trk.pos_last && i_in.valid && i_in.ready)
    `EMFP_ASSERT_NEXT(a_check_wraps,
        i_in.valid && i_in.ready && s_trk.pos_last && !i_in.gap_expired, s_trk.pos_zero)
    `EMFP_ASSERT_IMP(a_current_needs_power, o_out.valid && o_out.current_valid,
        o_out.power_valid)
    `EMFP_ASSERT_IMP(a_fault_no_flags, o_out.valid && o_out.frame_status != ST_OK,
        !o_out.voltage_valid && !o_out.current_valid && !o_out.power_valid)

endmodule

[rtl/core/emfp_tracker.sv]
// Frame position tracker: header checks, running checksum and field capture.
`timescale 1ns / 1ps
module emfp_tracker
    import emfp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    emfp_in_if.sink       i_in,
    input  logic          i_out_busy,
    output t_trk_stat     o_stat,
    output logic [7:0]    o_header,
    output logic [7:0]    o_adjust,
    output t_fields       o_fields
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_header, n_header;
    logic [7:0]        r_adjust, n_adjust;
    t_fields           r_fields;
    logic [POS_W-1:0]  s_pos_eff;
    logic              s_accept;
    logic              s_field_we;
    logic [FIDX_W-1:0] s_field_idx;
    logic              s_fire;

    // Only the checksum byte can produce a result, so only then must the output be free.
    assign i_in.ready = !i_out_busy || (r_pos != POS_CHECK);
    assign s_accept   = i_in.valid && i_in.ready;

    assign s_pos_eff = (i_in.gap_expired || r_pos >= POS_LIMIT) ? POS_HEADER : r_pos;
    assign s_field_idx = f_field_idx(s_pos_eff);

    always_comb begin
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_header   = r_header;
        n_adjust   = r_adjust;
        s_field_we = 1'b0;
        s_fire     = 1'b0;
        if (s_accept) begin
            if (s_pos_eff == POS_HEADER) begin
                if (i_in.rx_byte inside {HDR_NORMAL, HDR_UNCAL, [HDR_HIGH:8'hFF]}) begin
                    n_header = i_in.rx_byte;
                    n_sum    = 8'd0;
                    n_pos    = POS_SECOND;
                end else begin
                    n_pos = POS_HEADER;
                end
            end else if (s_pos_eff == POS_SECOND) begin
                n_pos = (i_in.rx_byte == HDR_SECOND) ? POS_W'(2) : POS_HEADER;
            end else if (s_pos_eff == POS_CHECK) begin
                n_pos  = POS_HEADER;
                s_fire = (r_sum == i_in.rx_byte);
            end else begin
                n_sum = r_sum + i_in.rx_byte;
                if (s_pos_eff <= POS_FIELD_LAST) begin
                    s_field_we = 1'b1;
                end else if (s_pos_eff == POS_ADJUST) begin
                    n_adjust = i_in.rx_byte;
                end
                n_pos = s_pos_eff + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HEADER;
            r_sum    <= 8'd0;
            r_header <= 8'd0;
            r_adjust <= 8'd0;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_header <= n_header;
            r_adjust <= n_adjust;
        end
    end

    // Fields arrive most significant byte first and shift in from the bottom.
    always_ff @(posedge i_clk) begin
        if (s_field_we) begin
            r_fields[s_field_idx] <= {r_fields[s_field_idx][15:0], i_in.rx_byte};
        end
    end

    assign o_stat.pos_last = (r_pos == POS_CHECK);
    assign o_stat.pos_zero = (r_pos == POS_HEADER);
    assign o_stat.fire     = s_fire;
    assign o_header        = r_header;
    assign o_adjust        = r_adjust;
    assign o_fields        = r_fields;

endmodule

[rtl/core/emfp_status.sv]
// Decodes the frame status and the three valid flags from header, adjust and power field values.
`timescale 1ns / 1ps
module emfp_status
    import emfp_pkg::*;
(
    input  logic [7:0] i_header,
    input  logic [7:0] i_adjust,
    input  t_word24    i_power_param,
    input  t_word24    i_power_period,
    output t_flags     o_flags
);

    logic s_range_on;
    logic s_vok;
    logic s_cok;
    logic s_pok;
    logic s_pval;
    logic s_power_nonzero;

    // Range bits only mean something when the header lies above the fault nibble base.
    assign s_range_on = (i_header > HDR_HIGH);
    assign s_vok = !(s_range_on && i_header[3]);
    assign s_cok = !(s_range_on && i_header[2]);
    assign s_pok = !(s_range_on && i_header[1]);

    assign s_pval = ((i_adjust & ADJ_POWER) != 8'd0) && s_vok && s_cok && s_pok;
    assign s_power_nonzero = s_pval && (i_power_param != 24'd0 || i_power_period == 24'd0);

    always_comb begin
        o_flags.status        = ST_OK;
        o_flags.voltage_valid = 1'b0;
        o_flags.current_valid = 1'b0;
        o_flags.power_valid   = 1'b0;
        if (i_header == HDR_UNCAL) begin
            o_flags.status = ST_UNCAL;
        end else if ((i_header & HDR_HIGH) == HDR_HIGH && i_header[0]) begin
            o_flags.status = ST_COEF_FAULT;
        end else begin
            o_flags.voltage_valid = ((i_adjust & ADJ_VOLTAGE) != 8'd0) && s_vok && s_cok;
            o_flags.power_valid   = s_pval;
            o_flags.current_valid = ((i_adjust & ADJ_CURRENT) != 8'd0) && s_vok && s_cok
                                    && s_power_nonzero;
        end
    end

endmodule

[rtl/core/emfp_out_reg.sv]
// Result register holding one parsed frame until the consumer takes it.
`timescale 1ns / 1ps
module emfp_out_reg
    import emfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_flags      i_flags,
    input  t_fields     i_fields,
    emfp_out_if.source  o_out,
    output logic        o_busy
);

    logic    r_valid, n_valid;
    t_flags  r_flags;
    t_fields r_fields;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags  <= i_flags;
            r_fields <= i_fields;
        end
    end

    assign o_busy               = r_valid && !o_out.ready;
    assign o_out.valid          = r_valid;
    assign o_out.frame_status   = r_flags.status;
    assign o_out.voltage_valid  = r_flags.voltage_valid;
    assign o_out.current_valid  = r_flags.current_valid;
    assign o_out.power_valid    = r_flags.power_valid;
    assign o_out.voltage_param  = r_fields[0];
    assign o_out.voltage_period = r_fields[1];
    assign o_out.current_param  = r_fields[2];
    assign o_out.current_period = r_fields[3];
    assign o_out.power_param    = r_fields[4];
    assign o_out.power_period   = r_fields[5];

endmodule
